>>> src/assert_macros.svh
// Assertion macros for the port-level checker acir_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> src/acir_pkg.sv
// Package for the infrared frame encoder: constants, types, maps.
// No dependencies.
package acir_pkg;
   localparam int unsigned PAYLOAD_LIMIT = 784;
   localparam logic [8:0] LEN_SHORT = 9'd199;
   localparam logic [8:0] LEN_LONG = 9'd299;
   localparam logic [12:0] DUR_LEADER = 13'd4400;
   localparam logic [12:0] DUR_GAP = 13'd5220;
   localparam logic [12:0] DUR_ONE = 13'd1620;
   localparam logic [12:0] DUR_BIT = 13'd540;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_TEMP = 3'd1;
   localparam logic [2:0] ERR_SWING = 3'd2;
   localparam logic [2:0] ERR_RATE = 3'd3;
   localparam logic [2:0] ERR_SHORT = 3'd4;
   localparam logic [2:0] ERR_LIMIT = 3'd5;

   localparam logic [2:0] REG_POWER = 3'd0;
   localparam logic [2:0] REG_MODE = 3'd1;
   localparam logic [2:0] REG_TEMP = 3'd2;
   localparam logic [2:0] REG_FAN = 3'd3;
   localparam logic [2:0] REG_SWING = 3'd4;
   localparam logic [2:0] REG_TIMER = 3'd5;
   localparam logic [2:0] REG_VARIANT = 3'd6;
   localparam logic [2:0] REG_RATE = 3'd7;

   // Divider start request and result.
   typedef struct packed {
      logic        start;
      logic [12:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [12:0] quotient;
   } div_rsp_type;

   function automatic logic [1:0] mode_map(input logic [2:0] m);
      case (m)
         3'd0: mode_map = 2'd2;
         3'd1: mode_map = 2'd0;
         3'd2: mode_map = 2'd1;
         3'd3: mode_map = 2'd1;
         default: mode_map = 2'd3;
      endcase
   endfunction

   function automatic logic [3:0] temp_map(input logic [3:0] ti);
      case (ti)
         4'd0: temp_map = 4'd0;
         4'd1: temp_map = 4'd1;
         4'd2: temp_map = 4'd3;
         4'd3: temp_map = 4'd2;
         4'd4: temp_map = 4'd6;
         4'd5: temp_map = 4'd7;
         4'd6: temp_map = 4'd5;
         4'd7: temp_map = 4'd4;
         4'd8: temp_map = 4'd12;
         4'd9: temp_map = 4'd13;
         4'd10: temp_map = 4'd9;
         4'd11: temp_map = 4'd8;
         4'd12: temp_map = 4'd10;
         default: temp_map = 4'd11;
      endcase
   endfunction

   function automatic logic [2:0] fan_hdr_map(input logic [1:0] f);
      case (f)
         2'd0: fan_hdr_map = 3'd5;
         2'd1: fan_hdr_map = 3'd4;
         2'd2: fan_hdr_map = 3'd2;
         default: fan_hdr_map = 3'd1;
      endcase
   endfunction

   function automatic logic [7:0] fan_tail_map(input logic [1:0] f);
      case (f)
         2'd0: fan_tail_map = 8'd102;
         2'd1: fan_tail_map = 8'd40;
         2'd2: fan_tail_map = 8'd60;
         default: fan_tail_map = 8'd100;
      endcase
   endfunction
endpackage

>>> src/acir_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on acir_pkg.
module acir_divider import acir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [12:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   // One shift-subtract step per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[12]} - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[16]) begin
            rem_in = {rem_ff[14:0], quo_ff[12]};
            quo_in = {quo_ff[11:0], 1'b0};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[11:0], 1'b1};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd12) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

>>> src/ac_ir_frame_pulse_encoder.sv
// Top level of the infrared frame encoder: registers, frame builder, sequencer.
// Depends on acir_pkg and acir_divider.
//
// Channel  | Dir | Contents
// req      | in  | tdata: begin_frame
// rsp      | out | tdata: duration, mark, quotient, varint bytes, length, error
// csr      | in  | write index and data
//
// An item goes from its transfer through these steps: start the shared serial
// divider, run the divide steps, raise the done flag, then encode the result.
// A setup error result is valid in the cycle after the transfer.
// Reset is synchronous and clears control state. The result waits in an
// output register; a new item is taken once that register is free and the
// sequencer is back in its idle state.
module ac_ir_frame_pulse_encoder import acir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] begin_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [12:0] duration_us, [13] is_mark, [26:14] compressed_value,
   // [34:27] code_byte_first, [42:35] code_byte_second, [50:43] code_byte_third,
   // [52:51] code_length, [55:53] error_code
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_START = 4'b0010,
      ST_DIV = 4'b0100,
      ST_OUT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic        power_ff, variant_ff;
   logic [2:0]  mode_ff, timer_ff;
   logic [5:0]  temp_ff;
   logic [1:0]  fan_ff;
   logic [7:0]  swing_ff;
   logic [15:0] rate_ff;
   logic [7:0]  hdr_ff [6];
   logic [7:0]  hdr_in [6];
   logic [7:0]  trl_ff [6];
   logic [7:0]  trl_in [6];
   logic [15:0] run_rate_ff, run_rate_in;
   logic [8:0]  run_len_ff, run_len_in;
   logic [8:0]  pos_ff, pos_in;
   logic [9:0]  pay_ff, pay_in;
   logic        active_ff, active_in;
   logic        ovalid_ff, ovalid_in;
   logic [55:0] odata_ff, odata_in;
   logic        olast_ff, olast_in;
   logic [12:0] dur_ff, dur_in;
   logic [2:0]  serr;
   div_req_type dreq;
   div_rsp_type drsp;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff <= 1'b1;
         mode_ff <= 3'd0;
         temp_ff <= 6'd24;
         fan_ff <= 2'd0;
         swing_ff <= 8'd0;
         timer_ff <= 3'd0;
         variant_ff <= 1'b0;
         rate_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_POWER: power_ff <= csr_wdata[0];
            REG_MODE: mode_ff <= csr_wdata[2:0];
            REG_TEMP: temp_ff <= csr_wdata[5:0];
            REG_FAN: fan_ff <= csr_wdata[1:0];
            REG_SWING: swing_ff <= csr_wdata[7:0];
            REG_TIMER: timer_ff <= csr_wdata[2:0];
            REG_VARIANT: variant_ff <= csr_wdata[0];
            REG_RATE: rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Header and trailer bytes from the registers, with setup error check.
   always_comb begin
      logic [2:0] m;
      logic [3:0] ti;
      logic [7:0] b2, nib, b4, sw;
      logic [9:0] swf;
      m = (mode_ff > 3'd4) ? 3'd4 : mode_ff;
      ti = 4'(temp_ff - 6'd17);
      b2 = '0;
      serr = ERR_NONE;
      for (int i = 0; i < 6; i++) hdr_in[i] = '0;
      hdr_in[0] = 8'hB2;
      hdr_in[1] = 8'h4D;
      swf = variant_ff ? {swing_ff, 2'b00} - 10'd1 : {1'b0, swing_ff, 1'b0} - 10'd1;
      sw = swf[7:0];
      if (m == 3'd0 || m == 3'd2) begin
         nib = {temp_map(ti), 4'd0};
      end else begin
         b2 = {fan_hdr_map(fan_ff), 5'd0};
         nib = (m != 3'd3) ? {temp_map(ti), 4'd0} : 8'hE0;
      end
      b4 = {4'd0, mode_map(m), 2'd0} | nib;
      if (!power_ff) begin
         hdr_in[2] = 8'h7B;
         hdr_in[3] = 8'h84;
         hdr_in[4] = 8'hE0;
         hdr_in[5] = 8'h1F;
      end else if (swing_ff != 8'd0) begin
         hdr_in[4] = {6'd0, sw[6:5]} | b4;
         hdr_in[2] = {3'd0, sw[4:0]} | b2;
         hdr_in[5] = (ti < 4'd9) ? 8'h7F : 8'hFF;
         hdr_in[3] = ~hdr_in[2];
      end else begin
         hdr_in[4] = b4;
         hdr_in[2] = b2 | 8'h1F;
         hdr_in[5] = ~b4;
         hdr_in[3] = ~hdr_in[2];
      end
      if (temp_ff < 6'd17 || temp_ff > 6'd30) serr = ERR_TEMP;
      else if (power_ff && swing_ff != 8'd0 && swf > 10'h7F) serr = ERR_SWING;
      else if (rate_ff == 16'd0) serr = ERR_RATE;
      trl_in[0] = 8'hD5;
      trl_in[1] = fan_tail_map(fan_ff);
      trl_in[2] = {timer_ff, 5'd0};
      trl_in[3] = 8'd0;
      trl_in[4] = 8'd0;
      trl_in[5] = 8'hD5 + trl_in[1] + trl_in[2];
   end

   // Duration of the current frame position.
   function automatic logic [12:0] bit_dur(input logic [7:0] bytes [6], input logic [6:0] k);
      logic [2:0] idx;
      idx = 3'(k[6:4]);
      if (!k[0]) bit_dur = DUR_BIT;
      else bit_dur = bytes[idx][3'd7 - k[3:1]] ? DUR_ONE : DUR_BIT;
   endfunction

   always_comb begin
      if (pos_ff < 9'd2) dur_in = DUR_LEADER;
      else if (pos_ff < 9'd98) dur_in = bit_dur(hdr_ff, 7'(pos_ff - 9'd2));
      else if (pos_ff == 9'd98) dur_in = DUR_BIT;
      else if (pos_ff == 9'd99) dur_in = DUR_GAP;
      else if (pos_ff < 9'd102) dur_in = DUR_LEADER;
      else if (pos_ff < 9'd198) dur_in = bit_dur(hdr_ff, 7'(pos_ff - 9'd102));
      else if (pos_ff == 9'd198) dur_in = DUR_BIT;
      else if (pos_ff == 9'd199) dur_in = DUR_GAP;
      else if (pos_ff < 9'd202) dur_in = DUR_LEADER;
      else if (pos_ff < 9'd298) dur_in = bit_dur(trl_ff, 7'(pos_ff - 9'd202));
      else dur_in = DUR_BIT;
   end

   // The divider starts from the duration of the position and bytes just latched.
   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign dreq.start = (state_ff == ST_START);
   assign dreq.dividend = dur_in;
   assign dreq.divisor = run_rate_ff;

   acir_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Sequencer and result encoding.
   always_comb begin
      logic [12:0] q;
      logic [9:0]  psum;
      logic [1:0]  len;
      logic [7:0]  c0, c1, c2;
      logic        mk;
      state_in = state_ff;
      pos_in = pos_ff;
      pay_in = pay_ff;
      active_in = active_ff;
      run_rate_in = run_rate_ff;
      run_len_in = run_len_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff;
      olast_in = olast_ff;
      q = drsp.quotient;
      mk = !pos_ff[0];
      c0 = '0; c1 = '0; c2 = '0; len = 2'd1;
      if (q <= 13'h7F) begin
         c0 = {1'b0, q[6:0]};
      end else begin
         c0 = {1'b1, q[6:0]}; c1 = {2'b0, q[12:7]}; len = 2'd2;
      end
      psum = pay_ff + {8'd0, len};
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tdata[0]) begin
                  pos_in = '0;
                  pay_in = '0;
                  if (serr != ERR_NONE) begin
                     active_in = 1'b0;
                     ovalid_in = 1'b1;
                     olast_in = 1'b1;
                     odata_in = {serr, 2'd1, 51'd0};
                  end else begin
                     active_in = 1'b1;
                     run_rate_in = rate_ff;
                     run_len_in = (power_ff && !variant_ff) ? LEN_LONG : LEN_SHORT;
                     state_in = ST_START;
                  end
               end else if (active_ff) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: if (drsp.done) state_in = ST_OUT;
         ST_OUT: begin
            state_in = ST_IDLE;
            ovalid_in = 1'b1;
            if (q == 13'd0) begin
               active_in = 1'b0;
               pos_in = '0;
               olast_in = 1'b1;
               odata_in = {ERR_SHORT, 2'd1, 24'd0, 13'd0, mk, dur_ff};
            end else if (psum > 10'(PAYLOAD_LIMIT)) begin
               active_in = 1'b0;
               pos_in = '0;
               pay_in = psum;
               olast_in = 1'b1;
               odata_in = {ERR_LIMIT, 2'd1, 24'd0, q, mk, dur_ff};
            end else begin
               pay_in = psum;
               olast_in = (pos_ff + 9'd1 >= run_len_ff);
               if (olast_in) begin
                  active_in = 1'b0;
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + 9'd1;
               end
               odata_in = {ERR_NONE, len, c2, c1, c0, q, mk, dur_ff};
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dur_ff <= dur_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      run_rate_ff <= run_rate_in;
      if (state_ff == ST_IDLE && req_tvalid && req_tready && req_tdata[0]) begin
         for (int i = 0; i < 6; i++) begin
            hdr_ff[i] <= hdr_in[i];
            trl_ff[i] <= trl_in[i];
         end
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         pay_ff <= '0;
         active_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         run_len_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         pay_ff <= pay_in;
         active_ff <= active_in;
         ovalid_ff <= ovalid_in;
         run_len_ff <= run_len_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tlast = olast_ff;
endmodule

>>> src/acir_checker.sv
// Port-level checker for the infrared frame encoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module acir_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);
   // An error result always ends the frame with no code bytes.
   `ASSERT_IMPL(a_err_last, clock, reset, rsp_tvalid && rsp_tdata[55:53] != 3'd0, rsp_tlast)
   `ASSERT_IMPL(a_err_len, clock, reset, rsp_tvalid && rsp_tdata[55:53] != 3'd0,
      rsp_tdata[52:51] == 2'd1 && rsp_tdata[50:27] == 24'd0)
   // No new item while a result waits.
   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // A frame start transfer closes ready on the next cycle.
   `ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready && req_tdata[0], !req_tready)
endmodule

bind ac_ir_frame_pulse_encoder acir_checker u_chk (.*);

>>> tb/acir_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the infrared frame encoder: it watches the request, result and register
// ports, predicts every pulse duration and compares the result channel field by field.
// Depends on acir_pkg for the register index and error codes.
module acir_frame_checker import acir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   typedef struct {
      bit [12:0] dur;
      bit        mark;
      bit [12:0] comp;
      bit [7:0]  b0;
      bit [7:0]  b1;
      bit [7:0]  b2;
      bit [1:0]  len;
      bit        last;
      bit [2:0]  err;
   } pulse_type;

   pulse_type expected_pulses[$];

   // Register copies.
   bit        cfg_power;
   bit [2:0]  cfg_mode;
   bit [5:0]  cfg_temp;
   bit [1:0]  cfg_fan;
   bit [7:0]  cfg_swing;
   bit [2:0]  cfg_timer;
   bit        cfg_variant;
   bit [15:0] cfg_rate;

   // Frame state.
   int unsigned pos, payload, run_rate, run_len;
   bit          active;
   bit [7:0]    hdr[6];
   bit [7:0]    trl[6];

   bit [1:0] mode_code[5] = '{2, 0, 1, 1, 3};
   bit [3:0] temp_code[14] = '{0, 1, 3, 2, 6, 7, 5, 4, 12, 13, 9, 8, 10, 11};
   bit [2:0] fan_head[4] = '{5, 4, 2, 1};
   bit [7:0] fan_tail[4] = '{102, 40, 60, 100};

   // Append one expected pulse at the tail of the queue.
   function void add_expected(pulse_type r);
      expected_pulses = {expected_pulses, r};
   endfunction

   // Latch the registers into header and trailer bytes; returns a setup error code.
   function bit [2:0] load_frame();
      int unsigned m, ti, b2, nib, b4, sw, sum;
      m = (cfg_mode > 4) ? 4 : cfg_mode;
      b2 = 0;
      if (cfg_temp < 17 || cfg_temp > 30) return ERR_TEMP;
      ti = cfg_temp - 17;
      hdr[0] = 8'hB2;
      hdr[1] = 8'h4D;
      if (!cfg_power) begin
         hdr[2] = 8'h7B;
         hdr[3] = 8'h84;
         hdr[4] = 8'hE0;
         hdr[5] = 8'h1F;
      end else begin
         if (m == 1 || m == 3 || m == 4) begin
            b2 = 32 * fan_head[cfg_fan];
            nib = (m != 3) ? 16 * temp_code[ti] : 8'hE0;
         end else begin
            nib = 16 * temp_code[ti];
         end
         b4 = ((4 * mode_code[m]) | nib) & 8'hFF;
         hdr[4] = b4;
         if (cfg_swing != 0) begin
            sw = (cfg_variant ? 4 : 2) * cfg_swing - 1;
            if (sw > 127) return ERR_SWING;
            hdr[4] = ((sw >> 5) & 3) | b4;
            hdr[2] = (sw & 5'h1F) | b2;
            hdr[5] = (ti < 9) ? 8'h7F : 8'hFF;
         end else begin
            hdr[2] = (b2 | 8'h1F) & 8'hFF;
            hdr[5] = ~b4 & 8'hFF;
         end
         hdr[3] = ~hdr[2];
      end
      if (cfg_rate == 0) return ERR_RATE;
      trl[0] = 8'hD5;
      trl[1] = fan_tail[cfg_fan];
      trl[2] = 32 * cfg_timer;
      trl[3] = 0;
      trl[4] = 0;
      sum = trl[0] + trl[1] + trl[2];
      trl[5] = sum & 8'hFF;
      run_rate = cfg_rate;
      run_len = (cfg_power && !cfg_variant) ? LEN_LONG : LEN_SHORT;
      return ERR_NONE;
   endfunction

   // Bit cell k of a six-byte block: even cells are marks, odd cells carry the bit.
   function int unsigned cell_length(bit use_trailer, int unsigned k);
      bit [7:0] byte_val;
      byte_val = use_trailer ? trl[(k / 16) % 6] : hdr[(k / 16) % 6];
      if ((k & 1) == 0) return DUR_BIT;
      return byte_val[7 - ((k % 16) / 2)] ? DUR_ONE : DUR_BIT;
   endfunction

   function int unsigned pulse_length(int unsigned p);
      if (p < 2) return DUR_LEADER;
      if (p < 98) return cell_length(0, p - 2);
      if (p == 98) return DUR_BIT;
      if (p == 99) return DUR_GAP;
      if (p < 102) return DUR_LEADER;
      if (p < 198) return cell_length(0, p - 102);
      if (p == 198) return DUR_BIT;
      if (p == 199) return DUR_GAP;
      if (p < 202) return DUR_LEADER;
      if (p < 298) return cell_length(1, p - 202);
      return DUR_BIT;
   endfunction

   // Work out the pulse caused by one request transfer, if any.
   function void predict_pulse(bit begin_frame);
      pulse_type r;
      bit [2:0] setup_err;
      int unsigned q;
      r = '{default: 0};
      r.len = 1;
      if (begin_frame) begin
         setup_err = load_frame();
         pos = 0;
         payload = 0;
         if (setup_err != ERR_NONE) begin
            active = 0;
            r.last = 1;
            r.err = setup_err;
            add_expected(r);
            return;
         end
         active = 1;
      end else if (!active) begin
         return;
      end
      r.dur = pulse_length(pos);
      r.mark = (pos & 1) == 0;
      q = r.dur / run_rate;
      r.comp = q;
      if (q == 0) begin
         active = 0;
         pos = 0;
         r.last = 1;
         r.err = ERR_SHORT;
         add_expected(r);
         return;
      end
      if (q <= 127) begin
         r.b0 = q;
         r.len = 1;
      end else if (q <= 16383) begin
         r.b0 = (q & 7'h7F) | 8'h80;
         r.b1 = (q >> 7) & 7'h7F;
         r.len = 2;
      end else begin
         r.b0 = (q & 7'h7F) | 8'h80;
         r.b1 = ((q >> 7) & 7'h7F) | 8'h80;
         r.b2 = (q >> 14) & 7'h7F;
         r.len = 3;
      end
      payload += r.len;
      if (payload > 1023) payload = 1023;
      if (payload > PAYLOAD_LIMIT) begin
         active = 0;
         pos = 0;
         r.b0 = 0;
         r.b1 = 0;
         r.b2 = 0;
         r.len = 1;
         r.last = 1;
         r.err = ERR_LIMIT;
         add_expected(r);
         return;
      end
      r.last = (pos + 1 >= run_len);
      if (r.last) begin
         active = 0;
         pos = 0;
      end else begin
         pos = (pos + 1) & 9'h1FF;
      end
      add_expected(r);
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pulse_type want;
      if (reset) begin
         cfg_power = 1; cfg_mode = 0; cfg_temp = 24; cfg_fan = 0;
         cfg_swing = 0; cfg_timer = 0; cfg_variant = 0; cfg_rate = 1;
         pos = 0; payload = 0; active = 0; run_rate = 1; run_len = 0;
         expected_pulses.delete();
         fail_count = 0;
      end else begin
         // Register writes.
         if (csr_we) begin
            case (csr_index)
               REG_POWER:   cfg_power = csr_wdata[0];
               REG_MODE:    cfg_mode = csr_wdata[2:0];
               REG_TEMP:    cfg_temp = csr_wdata[5:0];
               REG_FAN:     cfg_fan = csr_wdata[1:0];
               REG_SWING:   cfg_swing = csr_wdata[7:0];
               REG_TIMER:   cfg_timer = csr_wdata[2:0];
               REG_VARIANT: cfg_variant = csr_wdata[0];
               REG_RATE:    cfg_rate = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_pulse(req_tdata[0]);
         // Result transfer against the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pulses.size() == 0) begin
               $error("result transfer with no expected pulse");
               fail_count++;
            end else begin
               want = expected_pulses.pop_front();
               check_field("duration_us", want.dur, rsp_tdata[12:0]);
               check_field("is_mark", want.mark, rsp_tdata[13]);
               check_field("compressed_value", want.comp, rsp_tdata[26:14]);
               check_field("code_byte_first", want.b0, rsp_tdata[34:27]);
               check_field("code_byte_second", want.b1, rsp_tdata[42:35]);
               check_field("code_byte_third", want.b2, rsp_tdata[50:43]);
               check_field("code_length", want.len, rsp_tdata[52:51]);
               check_field("error_code", want.err, rsp_tdata[55:53]);
               check_field("frame_last", want.last, rsp_tlast);
            end
         end
      end
      pending = expected_pulses.size();
   end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the infrared frame encoder testbench: clock, reset, stimulus and verdict.
// Depends on acir_pkg, the encoder and acir_frame_checker.
module testbench;
   import acir_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEM_GOAL = 700;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_wdata = 0;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          items_sent = 0;
   int          cycles = 0;

   ac_ir_frame_pulse_encoder dut (.*);

   acir_frame_checker checker_inst (.*);

   always #10 clock = ~clock;

   // Receiver stalls.
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Run-away guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One request transfer with a random gap ahead of it; starts and ends at a falling edge.
   task automatic send_item(bit begin_frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {7'd0, begin_frame};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 0;
      items_sent++;
   endtask

   // Drain, then let the block settle before touching a register.
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic run_frame(int continues);
      send_item(1);
      repeat (continues) send_item(0);
   endtask

   task automatic pick_idling();
      case (items_sent / 60 % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 76; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 76; end
         default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
   endtask

   function automatic logic [15:0] pick_rate();
      case ($urandom_range(9))
         0: return 1;
         1: return 8;
         2: return 5;
         3: return 2;
         4: return 0;
         5: return 16'hFFFF;
         6: return 4401;
         7: return 541;
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   initial begin
      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Directed: default settings, an idle request, a restart mid-frame.
      send_item(0);
      run_frame(5);
      run_frame(3);
      settle();
      // Bad temperature at both ends, with power off too.
      write_reg(REG_TEMP, 16);
      run_frame(0);
      send_item(0);
      settle();
      write_reg(REG_POWER, 0);
      write_reg(REG_TEMP, 63);
      run_frame(0);
      settle();
      write_reg(REG_TEMP, 30);
      run_frame(2);
      settle();
      // Swing out of range, zero rate and a too-short pulse.
      write_reg(REG_POWER, 1);
      write_reg(REG_SWING, 255);
      run_frame(0);
      settle();
      write_reg(REG_SWING, 64);
      write_reg(REG_VARIANT, 0);
      write_reg(REG_RATE, 0);
      run_frame(0);
      settle();
      write_reg(REG_RATE, 16'hFFFF);
      run_frame(1);
      settle();
      write_reg(REG_TEMP, 17);
      write_reg(REG_MODE, 7);
      write_reg(REG_FAN, 3);
      write_reg(REG_TIMER, 7);
      write_reg(REG_RATE, 541);
      run_frame(3);
      settle();

      // Full frames: the long form at rate 1, then the short form at rate 8.
      write_reg(REG_SWING, 0);
      write_reg(REG_RATE, 1);
      run_frame(298);
      settle();
      write_reg(REG_VARIANT, 1);
      write_reg(REG_RATE, 8);
      write_reg(REG_SWING, 32);
      run_frame(198);
      settle();

      // Random settings and mostly short frames.
      while (items_sent < ITEM_GOAL) begin
         pick_idling();
         write_reg(REG_POWER, $urandom_range(9) != 0);
         write_reg(REG_MODE, $urandom_range(7));
         write_reg(REG_TEMP, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                       : $urandom_range(17, 30));
         write_reg(REG_FAN, $urandom_range(3));
         write_reg(REG_SWING, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                        : $urandom_range(0, 40));
         write_reg(REG_TIMER, $urandom_range(7));
         write_reg(REG_VARIANT, $urandom_range(1));
         write_reg(REG_RATE, pick_rate());
         repeat ($urandom_range(1, 3)) begin
            run_frame($urandom_range(0, 30));
            if ($urandom_range(3) == 0) send_item(0);
         end
         settle();
      end

      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
